// File: hdl/vmn_pkg.sv
// Shared types and constants for the three-axis mean and unit vector block.
package vmn_pkg;

  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int MEAN_W  = 24;
  localparam int UNIT_W  = 16;
  localparam int DVD_W   = 40;
  localparam int DVS_W   = 26;
  localparam int SQ_W    = 48;
  localparam int SQ_STEPS = 24;

  localparam logic [MEAN_W-1:0] MEAN_MAX_MAG = 24'd8388607;
  localparam logic [DVD_W-1:0]  MEAN_POS_LIM = 40'd8388607;
  localparam logic [DVD_W-1:0]  MEAN_NEG_LIM = 40'd8388608;
  localparam logic [DVD_W-1:0]  UNIT_ONE     = 40'd16384;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [CNT_W-1:0]        count;
  } vmn_run_t;

endpackage

// File: hdl/vmn_front.sv
// Front end: accumulates samples and closes a run when the count is reached.
module vmn_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic signed [15:0]    axis_x,
  input  logic signed [15:0]    axis_y,
  input  logic signed [15:0]    axis_z,
  input  logic [15:0]           sample_count,
  output logic                  run_push,
  output vmn_pkg::vmn_run_t     run_data
);
  import vmn_pkg::*;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]        samples_taken;
  logic signed [SUM_W-1:0] sx, sy, sz, nx, ny, nz;
  logic [CNT_W:0]          taken_inc, target;
  logic                    run_end;

  function automatic logic signed [SUM_W-1:0] sext(input logic [15:0] v);
    logic [63:0] raw;
    raw = 64'(v);
    return SUM_W'(signed'(raw[SAMPLE_WIDTH-1:0]));
  endfunction

  always_comb begin
    sx = sext(axis_x);
    sy = sext(axis_y);
    sz = sext(axis_z);
    nx = sum_x + sx;
    ny = sum_y + sy;
    nz = sum_z + sz;
    taken_inc = {1'b0, samples_taken} + 17'd1;
    target = (sample_count == '0) ? 17'd1 : {1'b0, sample_count};
    run_end = !(taken_inc < target);
    run_push = accept && run_end;
    run_data.sum_x = nx;
    run_data.sum_y = ny;
    run_data.sum_z = nz;
    run_data.count = taken_inc[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (run_end) begin
        sum_x <= '0;
        sum_y <= '0;
        sum_z <= '0;
        samples_taken <= '0;
      end else begin
        sum_x <= nx;
        sum_y <= ny;
        sum_z <= nz;
        samples_taken <= taken_inc[CNT_W-1:0];
      end
    end
  end

endmodule

// File: hdl/vmn_queue.sv
// Two-entry queue of closed runs between front and back.
module vmn_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vmn_pkg::vmn_run_t push_data,
  input  logic              take,
  output logic              full,
  output logic              ready,
  output vmn_pkg::vmn_run_t head
);
  import vmn_pkg::*;

  vmn_run_t   entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full  = fill == 2'd2;
  assign ready = fill != 2'd0;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (take) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(take);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");

endmodule

// File: hdl/vmn_div.sv
// Restoring divider, one quotient bit per cycle.
module vmn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vmn_pkg::DVD_W-1:0]  dividend,
  input  logic [vmn_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [vmn_pkg::DVD_W-1:0]  quotient
);
  import vmn_pkg::*;

  logic             busy;
  logic [5:0]       cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rs;
  logic [DVS_W-1:0] dvs;
  logic             ge;

  always_comb begin
    rs = {rem, quotient[DVD_W-1]};
    ge = rs >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DVS_W'(rs - {1'b0, dvs}) : rs[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 6'(DVD_W - 1);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DVD_W - 1)) busy <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/vmn_back.sv
// Back end: means, magnitude and unit vector for one closed run.
module vmn_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_ready,
  input  vmn_pkg::vmn_run_t        q_head,
  output logic                     q_take,
  input  logic                     pop,
  output logic                     empty,
  output logic signed [23:0]       mean_x,
  output logic signed [23:0]       mean_y,
  output logic signed [23:0]       mean_z,
  output logic [23:0]              magnitude,
  output logic signed [15:0]       unit_x,
  output logic signed [15:0]       unit_y,
  output logic signed [15:0]       unit_z,
  output logic                     zero_vector
);
  import vmn_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_SQRT   = 3'd4;
  localparam logic [2:0] S_USTART = 3'd5;
  localparam logic [2:0] S_UWAIT  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]              state;
  logic [1:0]              k;
  logic [4:0]              step;
  vmn_run_t                run;
  logic                    neg [3];
  logic [MEAN_W-1:0]       mabs [3];
  logic signed [MEAN_W-1:0] mean [3];
  logic signed [UNIT_W-1:0] unit [3];
  logic [SQ_W-1:0]         preg, acc, sx, sres;
  logic [SQ_W:0]           trial;
  logic [MEAN_W-1:0]       mag;
  logic                    out_valid;

  logic                    div_start, div_done;
  logic [DVD_W-1:0]        div_dvd, div_q;
  logic [DVS_W-1:0]        div_dvs;
  logic signed [SUM_W-1:0] cur_sum;
  logic [SUM_W-1:0]        cur_abs;
  logic [MEAN_W-1:0]       q_mag;
  logic                    q_sat;
  logic [DVD_W-1:0]        uq;
  logic [SQ_W-1:0]         bitv;

  vmn_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    case (k)
      2'd0:    cur_sum = run.sum_x;
      2'd1:    cur_sum = run.sum_y;
      default: cur_sum = run.sum_z;
    endcase
    cur_abs = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    div_start = state == S_MSTART || state == S_USTART;
    if (state == S_MSTART) begin
      div_dvd = {cur_abs, 8'd0};
      div_dvs = DVS_W'(run.count);
    end else begin
      div_dvd = DVD_W'({mabs[k], 15'd0}) + DVD_W'(mag);
      div_dvs = DVS_W'({mag, 1'b0});
    end
    if (neg[k]) q_sat = div_q > MEAN_NEG_LIM;
    else q_sat = div_q > MEAN_POS_LIM;
    q_mag = q_sat ? (neg[k] ? MEAN_MAX_MAG + 24'd1 : MEAN_MAX_MAG) : div_q[MEAN_W-1:0];
    uq = (div_q > UNIT_ONE) ? UNIT_ONE : div_q;
    bitv = SQ_W'(1) << {step, 1'b0};
    trial = {1'b0, sres} + {1'b0, bitv};
    q_take = state == S_IDLE && q_ready;
    empty = !out_valid;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (q_ready) run <= q_head;
      S_MSTART: neg[k] <= cur_sum[SUM_W-1];
      S_MWAIT: if (div_done) begin
        mabs[k] <= q_mag;
        mean[k] <= neg[k] ? MEAN_W'(-q_mag) : q_mag;
      end
      S_SQ: begin
        preg <= (k == 2'd3) ? '0 : SQ_W'(mabs[k] * mabs[k]);
        acc <= (k == 2'd0) ? '0 : acc + preg;
        sx <= acc + preg;
        sres <= '0;
      end
      S_SQRT: begin
        if (SQ_W'(sx) >= trial[SQ_W-1:0] && !trial[SQ_W]) begin
          sx <= sx - trial[SQ_W-1:0];
          sres <= (sres >> 1) + bitv;
        end else begin
          sres <= sres >> 1;
        end
        if (step == 5'd0) mag <= (sx >= trial[SQ_W-1:0] && !trial[SQ_W]) ?
            MEAN_W'((sres >> 1) + bitv) : MEAN_W'(sres >> 1);
      end
      S_UWAIT: if (div_done) unit[k] <= neg[k] ? UNIT_W'(-uq) : UNIT_W'(uq);
      default: ;
    endcase
    if (state == S_FIN && !out_valid) begin
      mean_x <= mean[0];
      mean_y <= mean[1];
      mean_z <= mean[2];
      magnitude <= mag;
      zero_vector <= mag == '0;
      unit_x <= (mag == '0) ? '0 : unit[0];
      unit_y <= (mag == '0) ? '0 : unit[1];
      unit_z <= (mag == '0) ? '0 : unit[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_ready) begin
          state <= S_MSTART;
          k <= '0;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: if (div_done) begin
          if (k == 2'd2) begin
            state <= S_SQ;
            k <= '0;
          end else begin
            k <= k + 2'd1;
            state <= S_MSTART;
          end
        end
        S_SQ: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_SQRT;
            step <= 5'(SQ_STEPS - 1);
          end
        end
        S_SQRT: begin
          step <= step - 5'd1;
          if (step == 5'd0) state <= S_USTART;
          k <= '0;
        end
        S_USTART: state <= (mag == '0) ? S_FIN : S_UWAIT;
        S_UWAIT: if (div_done) begin
          if (k == 2'd2) state <= S_FIN;
          else begin
            k <= k + 2'd1;
            state <= S_USTART;
          end
        end
        S_FIN: if (!out_valid) begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
      state == S_FIN && !out_valid |=> out_valid)
    else $error("result not loaded");
  a_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> zero_vector == (magnitude == '0))
    else $error("zero flag disagrees with magnitude");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> unit_x <= 16'sd16384 && unit_x >= -16'sd16384)
    else $error("unit component beyond one");
  a_take: assert property (@(posedge clk) disable iff (rst)
      q_take |=> state == S_MSTART)
    else $error("run taken outside idle");

endmodule

// File: hdl/vector_mean_normalize.sv
// Top level: three-axis running mean, magnitude and unit vector.
// Input: one sample per cycle while full is low; full rises only when two closed runs wait.
// A closed run passes through three mean divides, a square-and-sum pass, 24 root steps and
// three unit divides before its result reaches the ports; zero magnitude skips the unit divides.
// The back end takes a new run only from idle, after the last result is loaded; the shared
// one-bit-per-cycle divider and the root loop set its pace. Results stay on the ports until popped.
// Synchronous reset clears sums, count, queue and result flag; sample_count returns to 1000.
module vector_mean_normalize #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] mean_x,
  output logic signed [23:0] mean_y,
  output logic signed [23:0] mean_z,
  output logic [23:0]        magnitude,
  output logic signed [15:0] unit_x,
  output logic signed [15:0] unit_y,
  output logic signed [15:0] unit_z,
  output logic               zero_vector
);
  import vmn_pkg::*;

  logic [15:0] sample_count;
  logic        run_push, q_ready, q_take;
  vmn_run_t    run_data, q_head;

  always_ff @(posedge clk) begin
    if (rst) sample_count <= 16'd1000;
    else if (cfg_we) sample_count <= cfg_data;
  end

  vmn_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .accept(push && !full), .axis_x(axis_x), .axis_y(axis_y),
    .axis_z(axis_z), .sample_count(sample_count), .run_push(run_push), .run_data(run_data)
  );

  vmn_queue u_queue (
    .clk(clk), .rst(rst), .push(run_push), .push_data(run_data), .take(q_take),
    .full(full), .ready(q_ready), .head(q_head)
  );

  vmn_back u_back (
    .clk(clk), .rst(rst), .q_ready(q_ready), .q_head(q_head), .q_take(q_take),
    .pop(pop), .empty(empty), .mean_x(mean_x), .mean_y(mean_y), .mean_z(mean_z),
    .magnitude(magnitude), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .zero_vector(zero_vector)
  );

endmodule
